>>> rtl/core/nta_pkg.sv
// Shared constants, codes and types of the NFA trace acceptance core.
// No dependencies; every other file of the core depends on this package.
`default_nettype none
package nta_pkg;

    localparam int MAX_STATES = 32;
    localparam int MAX_PROPS  = 8;
    localparam int STATE_W    = $clog2(MAX_STATES);
    localparam int VAL_W      = MAX_PROPS;
    localparam int PROP_W     = 4;
    localparam int ADDR_W     = STATE_W + VAL_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_COUNT    = 2'd2;

    localparam logic [PROP_W-1:0] PROP_COUNT_RESET = 4'd8;

    typedef enum logic [1:0] {
        MODE_ADD_EDGE = 2'd0,
        MODE_START    = 2'd1,
        MODE_STEP     = 2'd2,
        MODE_NOP      = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_STEP,
        ST_STEP_LAST,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         mode;
        logic [STATE_W-1:0] source_state;
        logic [STATE_W-1:0] target_state;
        logic [VAL_W-1:0]   must_mask;
        logic [VAL_W-1:0]   must_not_mask;
        logic [VAL_W-1:0]   valuation;
    } t_item;

    typedef struct packed {
        logic [STATE_W-1:0] initial_state;
        logic [PROP_W-1:0]  prop_count;
    } t_cfg;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [MAX_STATES-1:0] wdata;
        logic [ADDR_W-1:0]     raddr;
    } t_mem_req;

endpackage
`default_nettype wire

>>> rtl/core/nta_in_if.sv
// Input channel of the NFA trace acceptance core: valid/ready and one item.
// Depends on nta_pkg for field widths.
`default_nettype none
interface nta_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic [nta_pkg::STATE_W-1:0] source_state;
    logic [nta_pkg::STATE_W-1:0] target_state;
    logic [nta_pkg::VAL_W-1:0]   must_mask;
    logic [nta_pkg::VAL_W-1:0]   must_not_mask;
    logic [nta_pkg::VAL_W-1:0]   valuation;

    modport source (
        output valid, mode, source_state, target_state, must_mask, must_not_mask, valuation,
        input  ready
    );
    modport sink (
        input  valid, mode, source_state, target_state, must_mask, must_not_mask, valuation,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/core/nta_out_if.sv
// Result channel of the NFA trace acceptance core: valid/ready and one result.
// Depends on nta_pkg for field widths.
`default_nettype none
interface nta_out_if;
    logic                           valid;
    logic                           ready;
    logic [nta_pkg::MAX_STATES-1:0] active_set;
    logic                           accepted;

    modport source (output valid, active_set, accepted, input ready);
    modport sink   (input valid, active_set, accepted, output ready);
endinterface
`default_nettype wire

>>> rtl/core/nfa_trace_acceptance_core.sv
// Top level of the NFA trace acceptance core: configuration registers,
// result register, sequencer and transition store. Depends on nta_pkg,
// nta_in_if, nta_out_if, nta_seq and nta_tstore.
// After reset all 8192 rows of the store are swept to zero; no item is taken then.
// One item at a time: start and no-op go straight to the result, a step does
// one store read per state, and an edge add does one read-modify-write per
// matching valuation.
`default_nettype none
module nfa_trace_acceptance_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    nta_in_if.sink                              i_in,
    nta_out_if.source                           o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [nta_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [nta_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import nta_pkg::*;

    logic [STATE_W-1:0]    r_initial_state;
    logic [MAX_STATES-1:0] r_final_mask;
    logic [PROP_W-1:0]     r_prop_count;
    logic                  r_out_valid;
    logic [MAX_STATES-1:0] r_out_active;
    logic                  r_out_accepted;

    t_item                 item;
    t_cfg                  cfg;
    t_mem_req              mem_req;
    logic [MAX_STATES-1:0] rdata;
    logic                  done;
    logic                  take;
    logic [MAX_STATES-1:0] active;

    always_comb begin
        item.mode          = i_in.mode;
        item.source_state  = i_in.source_state;
        item.target_state  = i_in.target_state;
        item.must_mask     = i_in.must_mask;
        item.must_not_mask = i_in.must_not_mask;
        item.valuation     = i_in.valuation;
        cfg.initial_state  = r_initial_state;
        cfg.prop_count     = r_prop_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_state <= '0;
            r_final_mask    <= '0;
            r_prop_count    <= PROP_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INITIAL_STATE: r_initial_state <= i_cfg_data[STATE_W-1:0];
                CFG_FINAL_MASK:    r_final_mask    <= i_cfg_data[MAX_STATES-1:0];
                CFG_PROP_COUNT:    r_prop_count    <= i_cfg_data[PROP_W-1:0];
                default: ;
            endcase
        end
    end

    assign take = done && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_active   <= active;
            r_out_accepted <= (active & r_final_mask) != '0;
        end
    end

    nta_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_item     (item),
        .i_cfg      (cfg),
        .o_mem      (mem_req),
        .i_rdata    (rdata),
        .o_done     (done),
        .i_take     (take),
        .o_active   (active)
    );

    nta_tstore u_tstore (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    assign o_out.valid      = r_out_valid;
    assign o_out.active_set = r_out_active;
    assign o_out.accepted   = r_out_accepted;
endmodule
`default_nettype wire

>>> rtl/core/nta_tstore.sv
// Transition store: one row of target bits per state and valuation.
// One write and one registered read port; depends on nta_pkg.
`default_nettype none
module nta_tstore (
    input  wire logic                           i_clk,
    input  wire nta_pkg::t_mem_req              i_req,
    output logic [nta_pkg::MAX_STATES-1:0]      o_rdata
);
    import nta_pkg::*;

    logic [MAX_STATES-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/nta_seq.sv
// Sequencer: clearing pass, guarded edge expansion and state-set stepping,
// all through the single port pair of the transition store. Depends on nta_pkg.
`default_nettype none
module nta_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire nta_pkg::t_item                i_item,
    input  wire nta_pkg::t_cfg                 i_cfg,
    output nta_pkg::t_mem_req                  o_mem,
    input  wire logic [nta_pkg::MAX_STATES-1:0] i_rdata,
    output logic                               o_done,
    input  wire logic                          i_take,
    output logic [nta_pkg::MAX_STATES-1:0]     o_active
);
    import nta_pkg::*;

    t_state                r_state, n_state;
    logic [ADDR_W-1:0]     r_cnt, n_cnt;
    t_item                 r_item, n_item;
    logic [VAL_W-1:0]      r_vmask, n_vmask;
    logic [VAL_W-1:0]      r_val, n_val;
    logic                  r_pend, n_pend;
    logic [MAX_STATES-1:0] r_acc, n_acc;
    logic [MAX_STATES-1:0] r_active, n_active;

    logic [PROP_W-1:0]     pc_sat;
    logic [VAL_W:0]        vfull;
    logic [VAL_W-1:0]      vmask;
    logic                  add_skip;
    logic [VAL_W-1:0]      v_cur;
    logic                  v_ok;
    logic                  v_last;
    logic [STATE_W-1:0]    s_cur;
    logic [MAX_STATES-1:0] row_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_active <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_pend   <= n_pend;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_vmask <= n_vmask;
        r_val   <= n_val;
        r_acc   <= n_acc;
    end

    always_comb begin
        pc_sat   = (i_cfg.prop_count > PROP_W'(MAX_PROPS)) ? PROP_W'(MAX_PROPS)
                                                           : i_cfg.prop_count;
        vfull    = ((VAL_W+1)'(1) << pc_sat) - (VAL_W+1)'(1);
        vmask    = vfull[VAL_W-1:0];
        add_skip = ({1'b0, i_item.source_state} >= (STATE_W+1)'(MAX_STATES))
                || ({1'b0, i_item.target_state} >= (STATE_W+1)'(MAX_STATES))
                || ((i_item.must_mask & i_item.must_not_mask) != '0)
                || ((i_item.must_mask & ~vmask) != '0);
        v_cur    = r_cnt[VAL_W-1:0];
        v_ok     = ((v_cur & r_item.must_mask) == r_item.must_mask)
                && ((v_cur & r_item.must_not_mask) == '0);
        v_last   = (v_cur == r_vmask);
        s_cur    = r_cnt[STATE_W-1:0];
        row_hit  = r_pend ? i_rdata : '0;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_item   = r_item;
        n_vmask  = r_vmask;
        n_val    = r_val;
        n_pend   = r_pend;
        n_acc    = r_acc;
        n_active = r_active;
        o_in_ready  = 1'b0;
        o_done      = 1'b0;
        o_mem.we    = 1'b0;
        o_mem.waddr = {r_item.source_state, v_cur};
        o_mem.wdata = i_rdata | (MAX_STATES'(1) << r_item.target_state);
        o_mem.raddr = {r_item.source_state, v_cur};

        case (r_state)
            ST_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_cnt;
                o_mem.wdata = '0;
                n_cnt       = r_cnt + ADDR_W'(1);
                if (r_cnt == '1) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item  = i_item;
                    n_cnt   = '0;
                    n_pend  = 1'b0;
                    n_acc   = '0;
                    n_vmask = vmask;
                    n_val   = i_item.valuation & vmask;
                    case (t_mode'(i_item.mode))
                        MODE_ADD_EDGE: n_state = add_skip ? ST_DONE : ST_ADD_RD;
                        MODE_START: begin
                            n_active = ({1'b0, i_cfg.initial_state}
                                        < (STATE_W+1)'(MAX_STATES))
                                     ? (MAX_STATES'(1) << i_cfg.initial_state) : '0;
                            n_state  = ST_DONE;
                        end
                        MODE_STEP: n_state = ST_STEP;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_ADD_RD: begin
                if (v_ok) begin
                    n_state = ST_ADD_WR;
                end else if (v_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            ST_ADD_WR: begin
                o_mem.we = 1'b1;
                if (v_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt   = r_cnt + ADDR_W'(1);
                    n_state = ST_ADD_RD;
                end
            end
            ST_STEP: begin
                o_mem.raddr = {s_cur, r_val};
                n_pend      = r_active[s_cur];
                n_acc       = r_acc | row_hit;
                if (s_cur == STATE_W'(MAX_STATES - 1)) begin
                    n_state = ST_STEP_LAST;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            ST_STEP_LAST: begin
                n_active = r_acc | row_hit;
                n_pend   = 1'b0;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                o_done = 1'b1;
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_active = r_active;
endmodule
`default_nettype wire
